### sv/ipsc_pkg.sv
// ----------------------------------------------------------------------------
// ipsc_pkg
// Types, codes and reset values shared by the idle power stage controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ipsc_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [COUNT_WIDTH-1:0] IDLE_MAX = {COUNT_WIDTH{1'b1}};

  localparam int ADDR_WIDTH = 5;

  // operation codes
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_POLL     = 3'd1;
  localparam logic [2:0] OP_ACTIVITY = 3'd2;
  localparam logic [2:0] OP_PRESS    = 3'd3;
  localparam logic [2:0] OP_WAKE     = 3'd4;

  // pending event bits
  localparam int EV_ACTIVITY = 0;
  localparam int EV_DIM      = 1;
  localparam int EV_OFF      = 2;
  localparam int EV_STOP     = 3;

  // display stages
  localparam logic [1:0] STAGE_ACTIVE = 2'd0;
  localparam logic [1:0] STAGE_DIMMED = 2'd1;
  localparam logic [1:0] STAGE_OFF    = 2'd2;

  // panel commands
  localparam logic [1:0] PANEL_NONE = 2'd0;
  localparam logic [1:0] PANEL_ON   = 2'd1;
  localparam logic [1:0] PANEL_OFF  = 2'd2;

  // stop commands
  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_ENTER   = 2'd1;
  localparam logic [1:0] STOP_REENTER = 2'd2;
  localparam logic [1:0] STOP_RESUME  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DIM_AFTER   = 3'd0;
  localparam logic [2:0] REG_OFF_AFTER   = 3'd1;
  localparam logic [2:0] REG_STOP_AFTER  = 3'd2;
  localparam logic [2:0] REG_HOLD_POLLS  = 3'd3;
  localparam logic [2:0] REG_REL_POLLS   = 3'd4;
  localparam logic [2:0] REG_DIM_LEVEL   = 3'd5;
  localparam logic [2:0] REG_NORM_LEVEL  = 3'd6;

  localparam logic [7:0] RST_DIM_AFTER  = 8'd20;
  localparam logic [7:0] RST_OFF_AFTER  = 8'd30;
  localparam logic [7:0] RST_STOP_AFTER = 8'd40;
  localparam logic [7:0] RST_HOLD_POLLS = 8'd40;
  localparam logic [7:0] RST_REL_POLLS  = 8'd3;
  localparam logic [7:0] RST_DIM_LEVEL  = 8'd5;
  localparam logic [7:0] RST_NORM_LEVEL = 8'd10;

  typedef struct packed {
    logic [2:0] operation;
    logic       key_level;
    logic       wake_by_key;
    logic       wake_by_motion;
    logic       raise_confirmed;
  } item_t;

  typedef struct packed {
    logic [1:0] panel_command;
    logic       backlight_write;
    logic [7:0] backlight_level;
    logic       refresh_request;
    logic [1:0] stop_command;
    logic       force_sensor_active;
    logic       power_off;
    logic [1:0] panel_stage;
    logic       shutdown_ready;
  } result_t;

  typedef struct packed {
    logic [7:0] dim_after_ticks;
    logic [7:0] off_after_ticks;
    logic [7:0] stop_after_ticks;
    logic [7:0] hold_polls_for_shutdown;
    logic [7:0] release_polls_to_arm;
    logic [7:0] dim_level;
    logic [7:0] normal_level;
  } cfg_t;

endpackage

`default_nettype wire

### sv/ipsc_core.sv
// ----------------------------------------------------------------------------
// ipsc_core
// Controller state and the per-request update: idle counting, event
// latching, long-press detection, event service and stop/wake handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ipsc_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire ipsc_pkg::item_t  item,
  input  wire ipsc_pkg::cfg_t   cfg,
  output ipsc_pkg::result_t     result
);

  logic [ipsc_pkg::COUNT_WIDTH-1:0] idle_count, idle_count_next;
  logic [1:0] stage, stage_next;
  logic [3:0] pending, pending_next;
  logic       in_stop, in_stop_next;
  logic       halted, halted_next;
  logic [7:0] hold_count, hold_count_next;
  logic [7:0] release_count, release_count_next;
  logic       armed, armed_next;
  logic       tracking, tracking_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count    <= '0;
      stage         <= ipsc_pkg::STAGE_ACTIVE;
      pending       <= '0;
      in_stop       <= 1'b0;
      halted        <= 1'b0;
      hold_count    <= '0;
      release_count <= '0;
      armed         <= 1'b0;
      tracking      <= 1'b0;
    end else if (fire) begin
      idle_count    <= idle_count_next;
      stage         <= stage_next;
      pending       <= pending_next;
      in_stop       <= in_stop_next;
      halted        <= halted_next;
      hold_count    <= hold_count_next;
      release_count <= release_count_next;
      armed         <= armed_next;
      tracking      <= tracking_next;
    end
  end

  logic [ipsc_pkg::COUNT_WIDTH-1:0] idle_inc;
  logic [ipsc_pkg::CMP_WIDTH-1:0]   idle_ext;
  logic [7:0] rel_inc;
  logic [7:0] hold_inc;
  logic       long_done;
  logic       restore;

  always_comb begin
    idle_count_next    = idle_count;
    stage_next         = stage;
    pending_next       = pending;
    in_stop_next       = in_stop;
    halted_next        = halted;
    hold_count_next    = hold_count;
    release_count_next = release_count;
    armed_next         = armed;
    tracking_next      = tracking;
    restore            = 1'b0;
    long_done          = 1'b0;
    result             = '0;

    idle_inc = (idle_count < ipsc_pkg::IDLE_MAX) ? idle_count + 1'b1 : idle_count;
    idle_ext = ipsc_pkg::CMP_WIDTH'(idle_inc);
    rel_inc  = (tracking && release_count < cfg.release_polls_to_arm) ?
               release_count + 8'd1 : release_count;
    hold_inc = (hold_count < cfg.hold_polls_for_shutdown) ?
               hold_count + 8'd1 : hold_count;

    if (!halted) begin
      case (item.operation)
        ipsc_pkg::OP_TICK: begin
          if (!in_stop) begin
            idle_count_next = idle_inc;
            if (stage == ipsc_pkg::STAGE_ACTIVE &&
                idle_ext >= ipsc_pkg::CMP_WIDTH'(cfg.dim_after_ticks))
              pending_next[ipsc_pkg::EV_DIM] = 1'b1;
            if (stage != ipsc_pkg::STAGE_OFF &&
                idle_ext >= ipsc_pkg::CMP_WIDTH'(cfg.off_after_ticks))
              pending_next[ipsc_pkg::EV_OFF] = 1'b1;
            if (idle_ext >= ipsc_pkg::CMP_WIDTH'(cfg.stop_after_ticks))
              pending_next[ipsc_pkg::EV_STOP] = 1'b1;
          end
        end
        ipsc_pkg::OP_POLL: begin
          if (!in_stop) begin
            pending_next = '0;
            // long press
            if (!item.key_level) begin
              hold_count_next    = '0;
              release_count_next = rel_inc;
              if (tracking && rel_inc >= cfg.release_polls_to_arm)
                armed_next = 1'b1;
            end else begin
              release_count_next = '0;
              if (!tracking || !armed) begin
                hold_count_next = '0;
              end else begin
                hold_count_next = hold_inc;
                long_done = hold_inc >= cfg.hold_polls_for_shutdown;
              end
            end
            // event service
            if (long_done) begin
              halted_next      = 1'b1;
              result.power_off = 1'b1;
            end else if (pending[ipsc_pkg::EV_ACTIVITY]) begin
              restore = 1'b1;
            end else if (pending[ipsc_pkg::EV_STOP]) begin
              in_stop_next        = 1'b1;
              result.stop_command = ipsc_pkg::STOP_ENTER;
            end else if (pending[ipsc_pkg::EV_OFF] && stage != ipsc_pkg::STAGE_OFF) begin
              result.backlight_write = 1'b1;
              result.backlight_level = '0;
              result.panel_command   = ipsc_pkg::PANEL_OFF;
              stage_next             = ipsc_pkg::STAGE_OFF;
            end else if (pending[ipsc_pkg::EV_DIM] && stage == ipsc_pkg::STAGE_ACTIVE) begin
              result.backlight_write = 1'b1;
              result.backlight_level = cfg.dim_level;
              stage_next             = ipsc_pkg::STAGE_DIMMED;
            end
          end
        end
        ipsc_pkg::OP_ACTIVITY: begin
          pending_next[ipsc_pkg::EV_ACTIVITY] = 1'b1;
        end
        ipsc_pkg::OP_PRESS: begin
          tracking_next = 1'b1;
        end
        ipsc_pkg::OP_WAKE: begin
          if (in_stop) begin
            if (item.wake_by_key) begin
              in_stop_next               = 1'b0;
              result.force_sensor_active = 1'b1;
              result.stop_command        = ipsc_pkg::STOP_RESUME;
              restore                    = 1'b1;
            end else if (item.wake_by_motion && item.raise_confirmed) begin
              in_stop_next        = 1'b0;
              result.stop_command = ipsc_pkg::STOP_RESUME;
              restore             = 1'b1;
            end else begin
              result.stop_command = ipsc_pkg::STOP_REENTER;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (restore) begin
      hold_count_next        = '0;
      release_count_next     = '0;
      armed_next             = 1'b0;
      tracking_next          = 1'b0;
      idle_count_next        = '0;
      result.panel_command   = ipsc_pkg::PANEL_ON;
      result.backlight_write = 1'b1;
      result.backlight_level = cfg.normal_level;
      result.refresh_request = 1'b1;
      stage_next             = ipsc_pkg::STAGE_ACTIVE;
    end

    result.panel_stage    = stage_next;
    result.shutdown_ready = armed_next;
  end

endmodule

`default_nettype wire

### sv/idle_power_stage_controller_unit.sv
// ----------------------------------------------------------------------------
// idle_power_stage_controller_unit
// Inactivity power sequencer: dims, turns off and stops the display on idle
// ticks, restores on activity or wake, and powers off on a long key press.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  item      item_valid/item_ready  item   (ipsc_pkg::item_t)
//  result    result_valid/ready     result (ipsc_pkg::result_t)
//  config    APB psel/penable       paddr, pwdata, prdata, pready
//
//  Each request yields one result in the output register on the next
//  cycle. A new request is taken whenever the output register is empty or
//  drains in the same cycle, so throughput is one per cycle. Synchronous
//  reset restores register defaults, clears core state and result_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_power_stage_controller_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_ready,
  input  wire ipsc_pkg::item_t                item,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output ipsc_pkg::result_t                   result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ipsc_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  ipsc_pkg::cfg_t    cfg;
  ipsc_pkg::result_t step_result;
  logic              fire;
  logic              wr_en;
  logic [2:0]        reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_after_ticks         <= ipsc_pkg::RST_DIM_AFTER;
      cfg.off_after_ticks         <= ipsc_pkg::RST_OFF_AFTER;
      cfg.stop_after_ticks        <= ipsc_pkg::RST_STOP_AFTER;
      cfg.hold_polls_for_shutdown <= ipsc_pkg::RST_HOLD_POLLS;
      cfg.release_polls_to_arm    <= ipsc_pkg::RST_REL_POLLS;
      cfg.dim_level               <= ipsc_pkg::RST_DIM_LEVEL;
      cfg.normal_level            <= ipsc_pkg::RST_NORM_LEVEL;
    end else if (wr_en) begin
      case (reg_index)
        ipsc_pkg::REG_DIM_AFTER:  cfg.dim_after_ticks         <= pwdata[7:0];
        ipsc_pkg::REG_OFF_AFTER:  cfg.off_after_ticks         <= pwdata[7:0];
        ipsc_pkg::REG_STOP_AFTER: cfg.stop_after_ticks        <= pwdata[7:0];
        ipsc_pkg::REG_HOLD_POLLS: cfg.hold_polls_for_shutdown <= pwdata[7:0];
        ipsc_pkg::REG_REL_POLLS:  cfg.release_polls_to_arm    <= pwdata[7:0];
        ipsc_pkg::REG_DIM_LEVEL:  cfg.dim_level               <= pwdata[7:0];
        ipsc_pkg::REG_NORM_LEVEL: cfg.normal_level            <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      ipsc_pkg::REG_DIM_AFTER:  prdata = {24'd0, cfg.dim_after_ticks};
      ipsc_pkg::REG_OFF_AFTER:  prdata = {24'd0, cfg.off_after_ticks};
      ipsc_pkg::REG_STOP_AFTER: prdata = {24'd0, cfg.stop_after_ticks};
      ipsc_pkg::REG_HOLD_POLLS: prdata = {24'd0, cfg.hold_polls_for_shutdown};
      ipsc_pkg::REG_REL_POLLS:  prdata = {24'd0, cfg.release_polls_to_arm};
      ipsc_pkg::REG_DIM_LEVEL:  prdata = {24'd0, cfg.dim_level};
      ipsc_pkg::REG_NORM_LEVEL: prdata = {24'd0, cfg.normal_level};
      default:                  prdata = '0;
    endcase
  end

  assign item_ready = !result_valid || result_ready;
  assign fire       = item_valid && item_ready;

  ipsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= step_result;
    end
  end

endmodule

`default_nettype wire
